// ----- hdl/nuri_pkg.sv -----
// Shared types and constants for the NDEF URI record parser.
// No dependencies; imported by every module of the block.
package nuri_pkg;

   localparam int MAX_BYTES  = 128;
   localparam int FIFO_DEPTH = 4;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

   localparam logic [7:0] TLV_NDEF_TAG  = 8'h03;
   localparam logic [7:0] TLV_LEN_ESC   = 8'hFF;
   localparam logic [7:0] URI_TYPE_BYTE = 8'h55;
   localparam logic [7:0] PRINT_LOW     = 8'h20;
   localparam logic [7:0] PRINT_HIGH    = 8'h7E;
   localparam logic [7:0] PREFIX_MAX    = 8'h04;
   localparam int         FLAG_SR_BIT   = 4;
   localparam int         FLAG_IL_BIT   = 3;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NO_TLV    = 3'd1;
   localparam logic [2:0] ST_TRUNCATED = 3'd2;
   localparam logic [2:0] ST_OVERRUN   = 3'd3;
   localparam logic [2:0] ST_NOT_URI   = 3'd4;

   typedef enum logic [3:0] {
      PH_SEARCH,
      PH_TLEN,
      PH_TLEN_HI,
      PH_TLEN_LO,
      PH_FLAGS,
      PH_TYPELEN,
      PH_PLEN,
      PH_IDLEN,
      PH_TYPE,
      PH_IDSKIP,
      PH_PREFIX,
      PH_PAYLOAD,
      PH_REJECT,
      PH_DONE
   } phase_type;

   // Results caused by one request: an optional character and an optional verdict.
   typedef struct packed {
      logic       char_valid;
      logic [7:0] char_value;
      logic       verdict_valid;
      logic [2:0] status;
      logic [2:0] prefix_code;
   } group_type;

endpackage

// ----- hdl/nuri_step.sv -----
// Parser state and per-byte update: one request is consumed per enabled cycle.
// Depends on nuri_pkg.
module nuri_step (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  logic [7:0]          data_byte,
   input  logic                final_byte,
   output nuri_pkg::group_type group
);
   import nuri_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [7:0]  pos_ff, pos_in;
   logic [15:0] tlv_len_ff, tlv_len_in;
   logic [7:0]  tlv_start_ff, tlv_start_in;
   logic [7:0]  flags_ff, flags_in;
   logic [7:0]  type_len_ff, type_len_in;
   logic [31:0] plen_ff, plen_in;
   logic [7:0]  id_len_ff, id_len_in;
   logic [7:0]  countdown_ff, countdown_in;
   logic        match_ff, match_in;
   logic [2:0]  prefix_ff, prefix_in;
   logic [31:0] pcount_ff, pcount_in;

   logic        take;
   logic        last;
   logic        enter_type;
   logic        finish_type;
   logic        emit;
   logic [31:0] need;
   logic [2:0]  status;
   logic [16:0] tlv_end;

   always_comb begin
      phase_in     = phase_ff;
      pos_in       = pos_ff;
      tlv_len_in   = tlv_len_ff;
      tlv_start_in = tlv_start_ff;
      flags_in     = flags_ff;
      type_len_in  = type_len_ff;
      plen_in      = plen_ff;
      id_len_in    = id_len_ff;
      countdown_in = countdown_ff;
      match_in     = match_ff;
      prefix_in    = prefix_ff;
      pcount_in    = pcount_ff;
      enter_type   = 1'b0;
      finish_type  = 1'b0;
      emit         = 1'b0;
      take         = fire && (pos_ff < 8'(MAX_BYTES));
      last         = final_byte || (pos_ff == 8'(MAX_BYTES - 1));
      need         = (plen_ff == 32'd0) ? 32'd0 : plen_ff - 32'd1;

      if (take) begin
         unique case (phase_ff)
            PH_SEARCH: begin
               if (data_byte == TLV_NDEF_TAG && !last) phase_in = PH_TLEN;
            end
            PH_TLEN: begin
               if (data_byte == TLV_LEN_ESC) begin
                  phase_in = PH_TLEN_HI;
               end else begin
                  tlv_len_in   = {8'h00, data_byte};
                  tlv_start_in = pos_ff + 8'd1;
                  phase_in     = PH_FLAGS;
               end
            end
            PH_TLEN_HI: begin
               tlv_len_in = {data_byte, 8'h00};
               phase_in   = PH_TLEN_LO;
            end
            PH_TLEN_LO: begin
               tlv_len_in   = tlv_len_ff | {8'h00, data_byte};
               tlv_start_in = pos_ff + 8'd1;
               phase_in     = PH_FLAGS;
            end
            PH_FLAGS: begin
               flags_in = data_byte;
               phase_in = PH_TYPELEN;
            end
            PH_TYPELEN: begin
               type_len_in  = data_byte;
               plen_in      = 32'd0;
               countdown_in = flags_ff[FLAG_SR_BIT] ? 8'd1 : 8'd4;
               phase_in     = PH_PLEN;
            end
            PH_PLEN: begin
               plen_in      = {plen_ff[23:0], data_byte};
               countdown_in = countdown_ff - 8'd1;
               if (countdown_ff == 8'd1) begin
                  if (flags_ff[FLAG_IL_BIT]) phase_in = PH_IDLEN;
                  else enter_type = 1'b1;
               end
            end
            PH_IDLEN: begin
               id_len_in  = data_byte;
               enter_type = 1'b1;
            end
            PH_TYPE: begin
               if (data_byte != URI_TYPE_BYTE) match_in = 1'b0;
               countdown_in = countdown_ff - 8'd1;
               if (countdown_ff == 8'd1) finish_type = 1'b1;
            end
            PH_IDSKIP: begin
               countdown_in = countdown_ff - 8'd1;
               if (countdown_ff == 8'd1) phase_in = PH_PREFIX;
            end
            PH_PREFIX: begin
               prefix_in = (data_byte <= PREFIX_MAX) ? data_byte[2:0] : 3'd0;
               pcount_in = 32'd0;
               phase_in  = (need == 32'd0) ? PH_DONE : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
               if (!(last && (pcount_ff + 32'd1 < need)) &&
                   data_byte >= PRINT_LOW && data_byte <= PRINT_HIGH) begin
                  emit = 1'b1;
               end
               pcount_in = pcount_ff + 32'd1;
               if (pcount_in >= need) phase_in = PH_DONE;
            end
            default: ;
         endcase
         pos_in = pos_ff + 8'd1;
      end

      if (enter_type) begin
         countdown_in = type_len_ff;
         match_in     = (type_len_ff == 8'd1);
         if (type_len_ff == 8'd0) finish_type = 1'b1;
         else phase_in = PH_TYPE;
      end

      if (finish_type) begin
         if (!match_in) begin
            phase_in = PH_REJECT;
         end else if (id_len_in == 8'd0) begin
            phase_in = PH_PREFIX;
         end else begin
            countdown_in = id_len_in;
            phase_in     = PH_IDSKIP;
         end
      end

      // Verdict sees the state after this byte was taken.
      tlv_end = {9'd0, tlv_start_in} + {1'b0, tlv_len_in};
      if (phase_in == PH_SEARCH) begin
         status = ST_NO_TLV;
      end else if (phase_in == PH_TLEN || phase_in == PH_TLEN_HI ||
                   phase_in == PH_TLEN_LO) begin
         status = ST_TRUNCATED;
      end else if (tlv_end > {9'd0, pos_in}) begin
         status = ST_OVERRUN;
      end else if (phase_in == PH_REJECT) begin
         status = ST_NOT_URI;
      end else if (phase_in == PH_PAYLOAD || phase_in == PH_DONE) begin
         status = ST_OK;
      end else begin
         status = ST_TRUNCATED;
      end

      group.char_valid    = emit;
      group.char_value    = data_byte;
      group.verdict_valid = fire && final_byte;
      group.status        = status;
      group.prefix_code   = (status == ST_OK) ? prefix_in : 3'd0;

      // Drop back to reset state for the next buffer.
      if (fire && final_byte) begin
         phase_in     = PH_SEARCH;
         pos_in       = 8'd0;
         tlv_len_in   = 16'd0;
         tlv_start_in = 8'd0;
         flags_in     = 8'd0;
         type_len_in  = 8'd0;
         plen_in      = 32'd0;
         id_len_in    = 8'd0;
         countdown_in = 8'd0;
         match_in     = 1'b0;
         prefix_in    = 3'd0;
         pcount_in    = 32'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SEARCH;
         pos_ff       <= 8'd0;
         tlv_len_ff   <= 16'd0;
         tlv_start_ff <= 8'd0;
         flags_ff     <= 8'd0;
         type_len_ff  <= 8'd0;
         plen_ff      <= 32'd0;
         id_len_ff    <= 8'd0;
         countdown_ff <= 8'd0;
         match_ff     <= 1'b0;
         prefix_ff    <= 3'd0;
         pcount_ff    <= 32'd0;
      end else begin
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         tlv_len_ff   <= tlv_len_in;
         tlv_start_ff <= tlv_start_in;
         flags_ff     <= flags_in;
         type_len_ff  <= type_len_in;
         plen_ff      <= plen_in;
         id_len_ff    <= id_len_in;
         countdown_ff <= countdown_in;
         match_ff     <= match_in;
         prefix_ff    <= prefix_in;
         pcount_ff    <= pcount_in;
      end
   end

endmodule

// ----- hdl/nuri_fifo.sv -----
// Result queue: holds per-request result groups and plays them out one item a beat.
// Depends on nuri_pkg.
module nuri_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  nuri_pkg::group_type push_group,
   output logic                full,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_is_verdict,
   output logic [7:0]          rsp_char_value,
   output logic [2:0]          rsp_status,
   output logic [2:0]          rsp_prefix_code
);
   import nuri_pkg::*;

   group_type            mem [FIFO_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 char_sent_ff, char_sent_in;
   group_type            head;
   logic                 char_pend;
   logic                 beat;
   logic                 pop;

   always_comb begin
      head            = mem[rd_ptr_ff];
      full            = (count_ff == CNT_W'(FIFO_DEPTH));
      rsp_valid       = (count_ff != '0);
      char_pend       = head.char_valid && !char_sent_ff;
      rsp_is_verdict  = !char_pend;
      rsp_char_value  = char_pend ? head.char_value : 8'd0;
      rsp_status      = char_pend ? ST_OK : head.status;
      rsp_prefix_code = char_pend ? 3'd0 : head.prefix_code;
      beat            = rsp_valid && rsp_ready;
      pop             = beat && (!char_pend || !head.verdict_valid);

      char_sent_in = char_sent_ff;
      if (pop) char_sent_in = 1'b0;
      else if (beat) char_sent_in = 1'b1;

      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) mem[wr_ptr_ff] <= push_group;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
         char_sent_ff <= 1'b0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
         char_sent_ff <= char_sent_in;
      end
   end

endmodule

// ----- hdl/ndef_uri_record_parser_core.sv -----
// Top level of the NDEF URI record parser; depends on nuri_pkg, nuri_step and nuri_fifo.
// The first result of a request passes the input register and then the result queue
//   before it is presented on rsp.
// Throughput: one request per cycle while the result queue has room; a final byte that
//   also yields a character needs a character and a verdict beat from the four-group queue.
// Reset (synchronous, active high) clears parser, input register and queue; no clearing pass.
module ndef_uri_record_parser_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_final_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_is_verdict,
   output logic [7:0] rsp_char_value,
   output logic [2:0] rsp_status,
   output logic [2:0] rsp_prefix_code
);
   import nuri_pkg::*;

   // Input register: hold one request until the parser can take it.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_data_ff, in_data_in;
   logic       in_final_ff, in_final_in;

   logic       fifo_full;
   logic       fire;
   logic       push;
   group_type  group;

   // Advance the parser only when the result queue has room for its group.
   assign fire      = in_valid_ff && !fifo_full;
   assign req_ready = !in_valid_ff || fire;
   // Push only groups that carry at least one result item.
   assign push      = group.char_valid || group.verdict_valid;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      in_final_in = in_final_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_data_in  = req_data_byte;
         in_final_in = req_final_byte;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      in_final_ff <= in_final_in;
   end

   nuri_step u_step (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .data_byte  (in_data_ff),
      .final_byte (in_final_ff),
      .group      (group)
   );

   nuri_fifo u_fifo (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .push_group      (group),
      .full            (fifo_full),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_is_verdict  (rsp_is_verdict),
      .rsp_char_value  (rsp_char_value),
      .rsp_status      (rsp_status),
      .rsp_prefix_code (rsp_prefix_code)
   );

   // Character items carry only printable bytes and no status or prefix.
   a_char_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_verdict |->
         rsp_char_value >= PRINT_LOW && rsp_char_value <= PRINT_HIGH &&
         rsp_status == ST_OK && rsp_prefix_code == 3'd0)
      else $error("character item malformed");

   // A failed verdict never reports a prefix.
   a_prefix_on_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_verdict && rsp_status != ST_OK |-> rsp_prefix_code == 3'd0)
      else $error("prefix reported on failed verdict");

   // The parser never advances into a full result queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      fire |-> !fifo_full)
      else $error("push into full result queue");

   // Nothing is presented right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("output not empty after reset");

endmodule
